// ===== hdl/tk_pkg.sv =====
// ----------------------------------------------------------------------------
// tk_pkg
// Shared types, constants and the ordering function of the top-k selector.
// ----------------------------------------------------------------------------
package tk_pkg;

  // Widths of the sample and result fields.
  localparam int DATA_W = 32;
  localparam int POS_W  = 16;

  // List depth and the widths that follow from it.
  localparam int MAX_KEEP = 16;
  localparam int KEEP_W   = $clog2(MAX_KEEP + 1);
  localparam int IDX_W    = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1;

  // Longest column that is counted exactly; later samples share this position.
  localparam logic [POS_W-1:0] MAX_COLUMN = 16'hFFFF;

  // Depth of the queue between the front and the back.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // Configuration register indexes (byte address bits [3:2]).
  localparam logic [1:0] REG_KEEP_COUNT    = 2'd0;
  localparam logic [1:0] REG_ORDER_MODE    = 2'd1;
  localparam logic [1:0] REG_SIGNED_VALUES = 2'd2;

  // One classified sample as it travels from the front to the back.
  typedef struct packed {
    logic [DATA_W-1:0] value;
    logic [POS_W-1:0]  position;
    logic              column_end;
    logic              overflow;
  } entry_t;

  // Compare settings seen by the back.
  typedef struct packed {
    logic [KEEP_W-1:0] keep;
    logic              order_mode;
    logic              signed_values;
  } cfg_t;

  // True when a strictly beats b under the given mode.
  function automatic logic beats(input logic [DATA_W-1:0] a,
                                 input logic [DATA_W-1:0] b,
                                 input logic order_mode,
                                 input logic signed_values);
    logic [DATA_W-1:0] ka;
    logic [DATA_W-1:0] kb;
    ka = a ^ {signed_values, {(DATA_W-1){1'b0}}};
    kb = b ^ {signed_values, {(DATA_W-1){1'b0}}};
    return order_mode ? (ka < kb) : (ka > kb);
  endfunction

endpackage

// ===== hdl/tk_front.sv =====
// ----------------------------------------------------------------------------
// tk_front
// Accepts samples, numbers them within the column and flags long columns.
// ----------------------------------------------------------------------------
module tk_front import tk_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [DATA_W-1:0] s_tdata,
  input  logic              s_tlast,
  output logic              push_valid,
  input  logic              push_ready,
  output entry_t            push_entry
);

  logic [POS_W-1:0] pos_count;
  logic             ovf_seen;
  logic             at_max;
  logic             accept;

  assign s_tready = push_ready;
  assign accept   = s_tvalid && push_ready;
  assign at_max   = (pos_count == MAX_COLUMN);

  // The position saturates; a sample arriving at the limit marks the column.
  always_comb begin
    push_valid            = s_tvalid;
    push_entry.value      = s_tdata;
    push_entry.position   = at_max ? pos_count : pos_count + POS_W'(1);
    push_entry.column_end = s_tlast;
    push_entry.overflow   = ovf_seen || at_max;
  end

  // Column counters restart after the last sample.
  always_ff @(posedge clk) begin
    if (rst) begin
      pos_count <= '0;
      ovf_seen  <= 1'b0;
    end else if (accept) begin
      if (s_tlast) begin
        pos_count <= '0;
        ovf_seen  <= 1'b0;
      end else begin
        pos_count <= push_entry.position;
        ovf_seen  <= push_entry.overflow;
      end
    end
  end

endmodule

// ===== hdl/tk_queue.sv =====
// ----------------------------------------------------------------------------
// tk_queue
// Small first-in first-out queue of classified samples.
// ----------------------------------------------------------------------------
module tk_queue import tk_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   push_valid,
  output logic   push_ready,
  input  entry_t push_entry,
  output logic   pop_valid,
  input  logic   pop_ready,
  output entry_t pop_entry
);

  entry_t            slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;
  logic              push;
  logic              pop;

  assign push_ready = (count != (QPTR_W+1)'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_entry  = slots[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  // Storage needs no reset; only the pointers do.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  // Pointer and occupancy bookkeeping.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + (QPTR_W+1)'(1);
      end else if (pop && !push) begin
        count <= count - (QPTR_W+1)'(1);
      end
    end
  end

  // Occupancy never exceeds the depth.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (QPTR_W+1)'(QUEUE_DEPTH))
    else $error("queue occupancy beyond depth");

  // A transfer into a full queue cannot happen.
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (count == (QPTR_W+1)'(QUEUE_DEPTH)) && !pop_ready |=> count == $past(count))
    else $error("queue overrun");

endmodule

// ===== hdl/tk_back.sv =====
// ----------------------------------------------------------------------------
// tk_back
// Compare-and-shift list of the best samples and the drain of the results.
// ----------------------------------------------------------------------------
module tk_back import tk_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  cfg_t              cfg,
  input  logic              pop_valid,
  output logic              pop_ready,
  input  entry_t            pop_entry,
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [DATA_W-1:0] m_value,
  output logic [POS_W-1:0]  m_position,
  output logic              m_tlast,
  output logic              m_tuser
);

  typedef enum logic [1:0] {
    ST_RUN   = 2'b01,
    ST_DRAIN = 2'b10
  } state_t;

  state_t            state;
  state_t            state_next;
  logic [DATA_W-1:0] vals [MAX_KEEP];
  logic [POS_W-1:0]  poss [MAX_KEEP];
  logic [KEEP_W-1:0] fill;
  logic [KEEP_W-1:0] fill_trim;
  logic [KEEP_W-1:0] fill_next;
  logic [IDX_W-1:0]  drain_idx;
  logic              col_ovf;
  logic              take;
  logic              load;
  logic              load_last;
  logic [MAX_KEEP-1:0] sel;
  logic [MAX_KEEP-1:0] after;
  logic [MAX_KEEP-1:0] in_k;
  logic              inserted;

  assign pop_ready = (state == ST_RUN);
  assign take      = pop_valid && pop_ready;
  assign load      = (state == ST_DRAIN) && (!m_tvalid || m_tready);
  assign load_last = ({1'b0, drain_idx} + KEEP_W'(1)) == fill;

  // A lowered keep count cuts the list before the next insertion.
  assign fill_trim = (fill > cfg.keep) ? cfg.keep : fill;

  // Find the first slot that the new sample beats or that is still empty.
  always_comb begin
    logic seen;
    logic hit;
    seen     = 1'b0;
    inserted = 1'b0;
    for (int i = 0; i < MAX_KEEP; i++) begin
      hit      = (KEEP_W'(i) >= fill_trim) ||
                 beats(pop_entry.value, vals[i], cfg.order_mode, cfg.signed_values);
      in_k[i]  = KEEP_W'(i) < cfg.keep;
      after[i] = seen;
      sel[i]   = hit && !seen;
      seen     = seen || hit;
      inserted = inserted || (sel[i] && in_k[i]);
    end
    fill_next = (inserted && (fill_trim < cfg.keep)) ? fill_trim + KEEP_W'(1) : fill_trim;
  end

  // Insert at the chosen slot and shift the worse entries down by one.
  always_ff @(posedge clk) begin
    if (take) begin
      for (int i = 0; i < MAX_KEEP; i++) begin
        if (in_k[i]) begin
          if (sel[i]) begin
            vals[i] <= pop_entry.value;
            poss[i] <= pop_entry.position;
          end else if (after[i] && i > 0) begin
            vals[i] <= vals[(i > 0) ? i - 1 : 0];
            poss[i] <= poss[(i > 0) ? i - 1 : 0];
          end
        end
      end
    end
  end

  // Sequencer: insert while running, emit the list after a column end.
  always_comb begin
    state_next = state;
    case (state)
      ST_RUN: begin
        if (take && pop_entry.column_end) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (load && load_last) begin
          state_next = ST_RUN;
        end
      end
      default: state_next = ST_RUN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_RUN;
      fill      <= '0;
      drain_idx <= '0;
      col_ovf   <= 1'b0;
    end else begin
      state <= state_next;
      if (take) begin
        fill      <= fill_next;
        drain_idx <= '0;
        col_ovf   <= pop_entry.overflow;
      end else if (load) begin
        if (load_last) begin
          fill <= '0;
        end else begin
          drain_idx <= drain_idx + IDX_W'(1);
        end
      end
    end
  end

  // Output register decouples the drain from the downstream ready.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_value    <= vals[drain_idx];
      m_position <= poss[drain_idx];
      m_tlast    <= load_last;
      m_tuser    <= col_ovf;
    end
  end

  // The list never grows past its storage.
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= KEEP_W'(MAX_KEEP))
    else $error("list fill beyond storage");

  // A drain always has at least one entry and stays inside the list.
  a_drain_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DRAIN) |-> (fill != '0) && ({1'b0, drain_idx} < fill))
    else $error("drain index outside the list");

  // Loading the final result empties the list and resumes insertion.
  a_drain_done: assert property (@(posedge clk) disable iff (rst)
    load && load_last |=> (state == ST_RUN) && (fill == '0) && m_tvalid && m_tlast)
    else $error("drain did not finish cleanly");

endmodule

// ===== hdl/top_k_select_with_index.sv =====
// ----------------------------------------------------------------------------
// top_k_select_with_index
// Streaming top-k selection: keeps the best k samples of a column with their
// 1-based positions and emits them best first after the column's last sample.
// ----------------------------------------------------------------------------
//  Channel  Dir  Handshake           Payload
//  s_*      in   s_tvalid/s_tready   tdata: sample_value; tlast: column_end
//  m_*      out  m_tvalid/m_tready   tdata: ranked_value, ranked_position;
//                                    tlast: run_end; tuser: count_overflow
//  APB      in   psel/penable/pready keep_count @0, order_mode @4, signed_values @8
//
// One sample per cycle is inserted into the compare-and-shift list while no drain
// is running. A column end starts a drain of the kept entries (1..16) through the
// single result register; a four-entry queue takes samples meanwhile.
// Reset clears the column counters, the list fill, the queue and the output;
// there is no clearing pass. Either side may stall at any time.
// ----------------------------------------------------------------------------
module top_k_select_with_index import tk_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  // Input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] sample_value
  input  logic        s_tlast,
  // Result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // [31:0] ranked_value, [47:32] ranked_position
  output logic        m_tlast,
  output logic        m_tuser,   // [0] count_overflow
  // Configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [4:0]        keep_count;
  logic              order_mode;
  logic              signed_values;
  logic              cfg_write;
  cfg_t              cfg;
  logic              push_valid;
  logic              push_ready;
  entry_t            push_entry;
  logic              pop_valid;
  logic              pop_ready;
  entry_t            pop_entry;
  logic [DATA_W-1:0] m_value;
  logic [POS_W-1:0]  m_position;

  // Register writes complete in the access phase.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      keep_count    <= 5'd1;
      order_mode    <= 1'b0;
      signed_values <= 1'b1;
    end else if (cfg_write) begin
      case (paddr[3:2])
        REG_KEEP_COUNT:    keep_count    <= pwdata[4:0];
        REG_ORDER_MODE:    order_mode    <= pwdata[0];
        REG_SIGNED_VALUES: signed_values <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_KEEP_COUNT:    prdata = {27'd0, keep_count};
      REG_ORDER_MODE:    prdata = {31'd0, order_mode};
      REG_SIGNED_VALUES: prdata = {31'd0, signed_values};
      default:           prdata = '0;
    endcase
  end

  // Effective keep count: zero acts as one, large values saturate.
  always_comb begin
    if (keep_count == 5'd0) begin
      cfg.keep = KEEP_W'(1);
    end else if (KEEP_W'(keep_count) > KEEP_W'(MAX_KEEP)) begin
      cfg.keep = KEEP_W'(MAX_KEEP);
    end else begin
      cfg.keep = KEEP_W'(keep_count);
    end
    cfg.order_mode    = order_mode;
    cfg.signed_values = signed_values;
  end

  tk_front u_front (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tlast    (s_tlast),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry)
  );

  tk_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_entry  (pop_entry)
  );

  tk_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_entry  (pop_entry),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_value    (m_value),
    .m_position (m_position),
    .m_tlast    (m_tlast),
    .m_tuser    (m_tuser)
  );

  assign m_tdata = {m_position, m_value};

endmodule

// ===== tb/top_k_select_with_index_checker.sv =====
// ----------------------------------------------------------------------------
// top_k_select_with_index_checker
// Watches the configuration port and both streams of the top-k selector. It
// keeps its own ranked list per column and checks every result transfer, in
// order and field by field, against the list predicted at each column end.
// ----------------------------------------------------------------------------
module top_k_select_with_index_checker import tk_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  // Input stream
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] sample_value
  input  logic        s_tlast,
  // Result stream
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [47:0] m_tdata,   // [31:0] ranked_value, [47:32] ranked_position
  input  logic        m_tlast,
  input  logic        m_tuser,   // [0] count_overflow
  // Configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  // Verdict
  output int          failures,
  output int          pending
);

  // One result as it should leave the block.
  typedef struct packed {
    logic [DATA_W-1:0] value;
    logic [POS_W-1:0]  position;
    logic              run_end;
    logic              overflow;
  } ranked_t;

  // Register copies.
  logic [KEEP_W-1:0] keep_reg;
  logic              smallest_first;
  logic              compare_signed;

  // Column state: the ranked list, its fill and the saturating position.
  logic [DATA_W-1:0] best_value [MAX_KEEP];
  logic [POS_W-1:0]  best_pos   [MAX_KEEP];
  int                best_fill;
  int                column_len;
  logic              column_over;

  // Results predicted but not yet seen on the result stream.
  ranked_t ranked_due [$];

  // True when a strictly ranks ahead of b under the current settings.
  function automatic logic outranks(input logic [31:0] a, input logic [31:0] b);
    if (compare_signed)
      return smallest_first ? ($signed(a) < $signed(b)) : ($signed(a) > $signed(b));
    return smallest_first ? (a < b) : (a > b);
  endfunction

  // Takes one sample into the list; on a column end queues the whole list.
  function automatic void rank_sample(input logic [31:0] v, input logic last);
    int      k;
    int      slot;
    int      i;
    ranked_t r;
    k = (keep_reg == 0) ? 1 : ((keep_reg > MAX_KEEP) ? MAX_KEEP : int'(keep_reg));
    // A lowered keep count drops the worst entries first.
    if (best_fill > k) best_fill = k;
    if (column_len >= int'(MAX_COLUMN)) begin
      column_len  = int'(MAX_COLUMN);
      column_over = 1'b1;
    end else begin
      column_len++;
    end
    // Equal values stay behind the earlier ones.
    slot = 0;
    while (slot < best_fill && !outranks(v, best_value[slot])) slot++;
    if (slot < k) begin
      for (i = (best_fill < k) ? best_fill : k - 1; i > slot; i--) begin
        best_value[i] = best_value[i-1];
        best_pos[i]   = best_pos[i-1];
      end
      best_value[slot] = v;
      best_pos[slot]   = column_len[POS_W-1:0];
      if (best_fill < k) best_fill++;
    end
    if (last) begin
      for (i = 0; i < best_fill; i++) begin
        r.value    = best_value[i];
        r.position = best_pos[i];
        r.run_end  = (i == best_fill - 1);
        r.overflow = column_over;
        ranked_due.push_back(r);
      end
      best_fill   = 0;
      column_len  = 0;
      column_over = 1'b0;
    end
  endfunction

  // Everything is sampled at the rising edge, before the block updates.
  always @(posedge clk) begin : watch
    ranked_t got;
    ranked_t want;
    if (rst) begin
      keep_reg       = 1;
      smallest_first = 1'b0;
      compare_signed = 1'b1;
      best_fill      = 0;
      column_len     = 0;
      column_over    = 1'b0;
      ranked_due.delete();
      failures       = 0;
    end else begin
      // Register writes.
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_KEEP_COUNT:    keep_reg = pwdata[KEEP_W-1:0];
          REG_ORDER_MODE:    smallest_first = pwdata[0];
          REG_SIGNED_VALUES: compare_signed = pwdata[0];
          default: ;
        endcase
      end

      // Sample transfers.
      if (s_tvalid && s_tready) rank_sample(s_tdata, s_tlast);

      // Result transfers.
      if (m_tvalid && m_tready) begin
        got.value    = m_tdata[31:0];
        got.position = m_tdata[47:32];
        got.run_end  = m_tlast;
        got.overflow = m_tuser;
        if (ranked_due.size() == 0) begin
          failures++;
          if (failures <= 10)
            $display("unexpected result: value %h position %0d end %b overflow %b",
                     got.value, got.position, got.run_end, got.overflow);
        end else begin
          want = ranked_due.pop_front();
          if (got.value !== want.value || got.position !== want.position ||
              got.run_end !== want.run_end || got.overflow !== want.overflow) begin
            failures++;
            if (failures <= 10)
              $display("mismatch: expected value %h position %0d end %b overflow %b, %s",
                       want.value, want.position, want.run_end, want.overflow,
                       $sformatf("got value %h position %0d end %b overflow %b",
                                 got.value, got.position, got.run_end, got.overflow));
          end
        end
      end
    end
    pending <= ranked_due.size();
  end

endmodule

// ===== tb/top_k_select_with_index_tb.sv =====
// ----------------------------------------------------------------------------
// top_k_select_with_index_tb
// Drives columns of samples and register settings into the top-k selector,
// with random gaps on the input and random back-pressure on the results.
// Directed columns cover the value extremes, ties, short columns, out-of-range
// keep counts and a settings change inside a column; random phases follow
// until about the planned number of samples has been sent.
// ----------------------------------------------------------------------------
module top_k_select_with_index_tb;
  import tk_pkg::*;

  localparam int RUN_LIMIT    = 2_000_000;
  localparam int DRAIN_GAP    = 40;
  localparam int DIRECTED     = 22;
  localparam int RANDOM_ITEMS = 240;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata  = '0;     // [31:0] sample_value
  logic        s_tlast  = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;           // [31:0] ranked_value, [47:32] ranked_position
  logic        m_tlast;
  logic        m_tuser;           // [0] count_overflow
  logic        psel     = 1'b0;
  logic        penable  = 1'b0;
  logic        pwrite   = 1'b0;
  logic [3:0]  paddr    = '0;
  logic [31:0] pwdata   = '0;
  logic [31:0] prdata;
  logic        pready;

  // No gaps or stalls on either side while this is set.
  logic calm = 1'b0;
  int   failures;
  int   pending;
  int   cycles = 0;
  int   sent   = 0;

  top_k_select_with_index dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .m_tuser(m_tuser),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  top_k_select_with_index_checker ranking_check (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .m_tuser(m_tuser),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .pready(pready), .failures(failures), .pending(pending)
  );

  // Clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Run limit.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= RUN_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Result side stalls about one cycle in five.
  always @(posedge clk) begin
    m_tready <= calm || ($urandom_range(0, 99) >= 21);
  end

  // Sample values biased toward ties and the signed and unsigned extremes.
  function automatic logic [31:0] random_value();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: begin
        case ($urandom_range(0, 4))
          0:       return 32'h0000_0000;
          1:       return 32'h0000_0001;
          2:       return 32'h7FFF_FFFF;
          3:       return 32'h8000_0000;
          default: return 32'hFFFF_FFFF;
        endcase
      end
      2:       return $urandom_range(0, 7);
      default: return 32'h7FFF_FFFC + $urandom_range(0, 7);
    endcase
  endfunction

  // One sample transfer, with a random gap in front of it.
  task automatic send_sample(input logic [31:0] value, input logic last);
    while (!calm && $urandom_range(0, 99) < 21) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= value;
    s_tlast  <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sent++;
  endtask

  // Setup and access phase of one register write; psel stays up for the next.
  task automatic write_reg(input logic [1:0] index, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {index, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
  endtask

  task automatic set_mode(input int keep, input logic smallest, input logic signed_cmp);
    write_reg(REG_KEEP_COUNT, keep);
    write_reg(REG_ORDER_MODE, {31'd0, smallest});
    write_reg(REG_SIGNED_VALUES, {31'd0, signed_cmp});
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Waits until every predicted result has come out and the queue has drained.
  task automatic settle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_GAP) @(posedge clk);
  endtask

  initial begin : stimulus
    int   k;
    int   cols;
    int   len;
    int   c;
    int   j;
    int   phase;
    logic open;

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings: one largest signed value.
    send_sample(32'h0000_0000, 1'b0);
    send_sample(32'h8000_0000, 1'b1);
    settle();

    // Signed extremes with a tie on the largest value.
    set_mode(4, 1'b0, 1'b1);
    send_sample(32'h7FFF_FFFF, 1'b0);
    send_sample(32'h8000_0000, 1'b0);
    send_sample(32'h0000_0000, 1'b0);
    send_sample(32'hFFFF_FFFF, 1'b0);
    send_sample(32'h7FFF_FFFF, 1'b0);
    send_sample(32'h0000_0001, 1'b1);
    settle();

    // Keep count zero acts as one; smallest unsigned, tie on zero.
    set_mode(0, 1'b1, 1'b0);
    send_sample(32'h0000_0005, 1'b0);
    send_sample(32'h0000_0000, 1'b0);
    send_sample(32'hFFFF_FFFF, 1'b0);
    send_sample(32'h0000_0000, 1'b1);
    settle();

    // Keep count above the list depth saturates; column shorter than k.
    set_mode(31, 1'b0, 1'b0);
    send_sample(32'hFFFF_FFFF, 1'b0);
    send_sample(32'h8000_0000, 1'b0);
    send_sample(32'h0000_0001, 1'b1);
    settle();

    // Keep count lowered and order flipped inside a column.
    set_mode(8, 1'b0, 1'b1);
    send_sample(32'h0000_0010, 1'b0);
    send_sample(32'h0000_0020, 1'b0);
    send_sample(32'hFFFF_FFF0, 1'b0);
    send_sample(32'h0000_0030, 1'b0);
    send_sample(32'h0000_0040, 1'b0);
    settle();
    set_mode(2, 1'b1, 1'b1);
    send_sample(32'h0000_0035, 1'b0);
    send_sample(32'h8000_0000, 1'b1);
    settle();

    // Random phases: new settings, a few columns, sometimes one left open.
    phase = 0;
    while (sent < DIRECTED + RANDOM_ITEMS) begin
      calm <= (phase >= 3 && phase < 6);
      case ($urandom_range(0, 3))
        0:       k = 1;
        1:       k = MAX_KEEP;
        2:       k = $urandom_range(0, 31);
        default: k = $urandom_range(2, 6);
      endcase
      set_mode(k, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      cols = $urandom_range(1, 4);
      for (c = 0; c < cols; c++) begin
        len  = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 20);
        open = (c == cols - 1) && ($urandom_range(0, 5) == 0);
        for (j = 0; j < len; j++) send_sample(random_value(), !open && (j == len - 1));
      end
      settle();
      phase++;
    end

    if (failures == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
